// ----- rtl/qpu_pkg.sv -----
// Shared types, constants and arithmetic helpers for the quickprop update block.
package qpu_pkg;

    // Input item function codes.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GROWTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_MODE  = 2'd2;

    localparam logic [15:0] LEARN_RATE_RESET = 16'd6144;
    localparam logic [15:0] MAX_GROWTH_RESET = 16'd7168;
    localparam logic        RULE_MODIFIED    = 1'b0;
    localparam logic        RULE_ORIGINAL    = 1'b1;

    // Fixed point: Q4.12 factors.
    localparam int unsigned FRAC_BITS = 12;
    localparam logic [16:0] ONE_Q12 = 17'd4096;

    // Divider: 64-bit dividend magnitude, 33-bit divisor magnitude.
    localparam int unsigned NUM_W = 64;
    localparam int unsigned DEN_W = 33;
    localparam int unsigned DIV_BITS = 2;
    localparam int unsigned DIV_STAGES = NUM_W / DIV_BITS;

    typedef struct packed {
        logic               func;
        logic [9:0]         elem_index;
        logic signed [31:0] operand_value;
    } in_item_t;

    typedef struct packed {
        logic [9:0]         out_index;
        logic signed [31:0] new_point;
        logic signed [31:0] new_step;
        logic               skipped;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] point;
        logic signed [31:0] deriv;
        logic signed [31:0] step;
    } ram_word_t;

    // Per-item context that travels alongside the arithmetic.
    typedef struct packed {
        logic               func;
        logic               in_range;
        logic [9:0]         idx;
        logic signed [31:0] d;
        logic signed [31:0] o;
        logic signed [31:0] s;
        logic signed [31:0] p;
        logic               eq;
        logic signed [47:0] g;
        logic signed [47:0] m;
        logic [47:0]        lim;
        logic               gt;
        logic               lt;
    } work_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] nq;
    } div_state_t;

    // One restoring division step: dividend bits shift out of nq, quotient bits shift in.
    function automatic div_state_t div_step(div_state_t st, logic [DEN_W-1:0] den);
        logic [DEN_W:0] tmp;
        div_state_t     r;
        tmp  = {st.rem, st.nq[NUM_W-1]};
        r.nq = {st.nq[NUM_W-2:0], 1'b0};
        if (tmp >= {1'b0, den})
        begin
            tmp     = tmp - {1'b0, den};
            r.nq[0] = 1'b1;
        end
        r.rem = tmp[DEN_W-1:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// ----- rtl/qpu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module qpu_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/qpu_div.sv -----
// Pipelined signed-magnitude divider, two quotient bits per stage, with item context.
module qpu_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [qpu_pkg::NUM_W-1:0]    num,
    input  logic [qpu_pkg::DEN_W-1:0]    den,
    input  logic                         qneg,
    input  qpu_pkg::work_t               side,
    input  logic [9:0]                   probe_idx,
    output logic                         probe_hit,
    output logic                         out_valid,
    output logic [qpu_pkg::NUM_W-1:0]    quot,
    output logic                         out_qneg,
    output qpu_pkg::work_t               out_side
);

    localparam int unsigned NS = qpu_pkg::DIV_STAGES;

    logic [NS-1:0]              vld_reg;
    qpu_pkg::div_state_t        st_reg   [NS];
    logic [qpu_pkg::DEN_W-1:0]  den_reg  [NS];
    logic [NS-1:0]              neg_reg;
    qpu_pkg::work_t             side_reg [NS];
    logic [NS-1:0]              hit_vec;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic                       vld_in;
        qpu_pkg::div_state_t        st_in;
        logic [qpu_pkg::DEN_W-1:0]  den_in;
        logic                       neg_in;
        qpu_pkg::work_t             side_in;
        qpu_pkg::div_state_t        st_next;

        if (k == 0)
        begin : g_first
            assign vld_in     = in_valid;
            assign st_in.rem  = '0;
            assign st_in.nq   = num;
            assign den_in     = den;
            assign neg_in     = qneg;
            assign side_in    = side;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[k-1];
            assign st_in   = st_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign neg_in  = neg_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            st_next = st_in;
            for (int b = 0; b < qpu_pkg::DIV_BITS; b++)
                st_next = qpu_pkg::div_step(st_next, den_in);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            st_reg[k]   <= st_next;
            den_reg[k]  <= den_in;
            neg_reg[k]  <= neg_in;
            side_reg[k] <= side_in;
        end

        assign hit_vec[k] = vld_reg[k] && (side_reg[k].idx == probe_idx);
    end

    assign probe_hit = |hit_vec;
    assign out_valid = vld_reg[NS-1];
    assign quot      = st_reg[NS-1].nq;
    assign out_qneg  = neg_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

// ----- rtl/quickprop_update_top.sv -----
// Quickprop per-element update engine: top level with state RAM and arithmetic pipeline.
//
// An item is accepted when start is high and busy is low; its result appears on result
// with a one-cycle done strobe, and a new item can be accepted every cycle unless busy.
// The pipeline is the 32-stage divider that forms the secant step, plus two stages before
// it (state RAM read, products), four after it (sign, rule, clamp, saturation) and the
// result register. Busy is raised while an item for the same elem_index is still in the
// pipeline, since its state is written back only at the end, and after reset while a
// clearing pass zeroes the state RAM. Results cannot be held off by the receiver.
module quickprop_update_top #(
    parameter int unsigned ELEMENTS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  qpu_pkg::in_item_t                    item,
    output logic                                 done,
    output qpu_pkg::out_item_t                   result,
    input  logic                                 cfg_we,
    input  logic [qpu_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [qpu_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int unsigned AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int unsigned RW = $bits(qpu_pkg::ram_word_t);

    // Configuration.
    logic [15:0] learn_rate_reg;
    logic [15:0] max_growth_reg;
    logic        rule_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= qpu_pkg::LEARN_RATE_RESET;
            max_growth_reg <= qpu_pkg::MAX_GROWTH_RESET;
            rule_mode_reg  <= qpu_pkg::RULE_MODIFIED;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                qpu_pkg::REG_LEARN_RATE: learn_rate_reg <= cfg_wdata;
                qpu_pkg::REG_MAX_GROWTH: max_growth_reg <= cfg_wdata;
                qpu_pkg::REG_RULE_MODE:  rule_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Clearing pass after reset.
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(ELEMENTS - 1))
                clr_active_reg <= 1'b0;
        end
    end

    // Hazard detection against every stage in flight.
    logic div_hit;
    logic pipe_hit;
    logic accept;

    // Stage 1: RAM read data returns.
    logic               p1_valid_reg;
    logic               p1_func_reg;
    logic               p1_inr_reg;
    logic [9:0]         p1_idx_reg;
    logic signed [31:0] p1_d_reg;

    // Stage 2: products.
    logic               p2_valid_reg;
    qpu_pkg::work_t     p2_work_reg;
    logic signed [63:0] p2_ds_reg;
    logic signed [48:0] p2_g_reg;
    logic signed [48:0] p2_m_reg;
    logic signed [49:0] p2_lhs_reg;
    logic signed [48:0] p2_rhs_reg;

    // Stages after the divider.
    logic               a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    qpu_pkg::work_t     a_work_reg, b_work_reg, c_work_reg, d_work_reg;
    logic signed [63:0] a_q_reg;
    logic signed [63:0] b_delta_reg;
    logic               b_clamp_reg;
    logic signed [63:0] c_delta_reg;
    logic signed [31:0] d_step_reg;

    assign pipe_hit = (p1_valid_reg && p1_idx_reg == item.elem_index)
                   || (p2_valid_reg && p2_work_reg.idx == item.elem_index)
                   || div_hit
                   || (a_valid_reg && a_work_reg.idx == item.elem_index)
                   || (b_valid_reg && b_work_reg.idx == item.elem_index)
                   || (c_valid_reg && c_work_reg.idx == item.elem_index)
                   || (d_valid_reg && d_work_reg.idx == item.elem_index);

    assign busy   = clr_active_reg || pipe_hit;
    assign accept = start && !busy;

    // State RAM.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    qpu_pkg::ram_word_t ram_wdata;
    qpu_pkg::ram_word_t ram_rdata;
    logic [RW-1:0]     ram_rdata_bits;

    qpu_ram #(
        .WIDTH (RW),
        .DEPTH (ELEMENTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (AW'(item.elem_index)),
        .rdata (ram_rdata_bits)
    );

    assign ram_rdata = ram_rdata_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        p1_func_reg <= item.func;
        p1_inr_reg  <= (32'(item.elem_index) < ELEMENTS);
        p1_idx_reg  <= item.elem_index;
        p1_d_reg    <= item.operand_value;
    end

    // Stage 1 -> 2: form all products.
    logic signed [16:0] lr_s;
    logic signed [16:0] mg_s;
    logic signed [17:0] mg1_s;
    qpu_pkg::work_t     p1_work;

    always_comb
    begin
        lr_s  = $signed({1'b0, learn_rate_reg});
        mg_s  = $signed({1'b0, max_growth_reg});
        mg1_s = $signed({1'b0, qpu_pkg::ONE_Q12 + {1'b0, max_growth_reg}});
        p1_work          = '0;
        p1_work.func     = p1_func_reg;
        p1_work.in_range = p1_inr_reg;
        p1_work.idx      = p1_idx_reg;
        p1_work.d        = p1_d_reg;
        p1_work.o        = ram_rdata.deriv;
        p1_work.s        = ram_rdata.step;
        p1_work.p        = ram_rdata.point;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        p2_work_reg <= p1_work;
        p2_ds_reg   <= p1_d_reg * ram_rdata.step;
        p2_g_reg    <= lr_s * p1_d_reg;
        p2_m_reg    <= mg_s * ram_rdata.step;
        p2_lhs_reg  <= mg1_s * p1_d_reg;
        p2_rhs_reg  <= mg_s * ram_rdata.deriv;
    end

    // Stage 2: divider operands and side terms.
    logic signed [32:0] den_s;
    logic [32:0]        den_abs;
    logic [63:0]        num_abs;
    logic [48:0]        m_abs;
    logic signed [49:0] rhs_ext;
    qpu_pkg::work_t     p2_work;

    always_comb
    begin
        den_s   = {p2_work_reg.o[31], p2_work_reg.o} - {p2_work_reg.d[31], p2_work_reg.d};
        den_abs = den_s[32] ? 33'(-den_s) : 33'(den_s);
        num_abs = p2_ds_reg[63] ? 64'(-p2_ds_reg) : 64'(p2_ds_reg);
        m_abs   = p2_m_reg[48] ? 49'(-p2_m_reg) : 49'(p2_m_reg);
        rhs_ext = 50'(p2_rhs_reg);
        p2_work     = p2_work_reg;
        p2_work.eq  = (p2_work_reg.o == p2_work_reg.d);
        p2_work.g   = 48'(p2_g_reg >>> qpu_pkg::FRAC_BITS);
        p2_work.m   = 48'(p2_m_reg >>> qpu_pkg::FRAC_BITS);
        p2_work.lim = 48'(m_abs >> qpu_pkg::FRAC_BITS);
        p2_work.gt  = (p2_lhs_reg > rhs_ext);
        p2_work.lt  = (p2_lhs_reg < rhs_ext);
    end

    logic               dv_valid;
    logic [63:0]        dv_quot;
    logic               dv_qneg;
    qpu_pkg::work_t     dv_work;

    qpu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_valid_reg),
        .num       (num_abs),
        .den       (den_abs),
        .qneg      (p2_ds_reg[63] ^ den_s[32]),
        .side      (p2_work),
        .probe_idx (item.elem_index),
        .probe_hit (div_hit),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_qneg  (dv_qneg),
        .out_side  (dv_work)
    );

    // Stage A: apply quotient sign.
    always_ff @(posedge clk)
    begin
        a_work_reg <= dv_work;
        a_q_reg    <= dv_qneg ? $signed(-dv_quot) : $signed(dv_quot);
    end

    // Stage B: rule selection.
    logic signed [63:0] g64;
    logic signed [63:0] m64;
    logic signed [63:0] base;
    logic signed [63:0] addend;
    logic               b_clamp;
    logic               dpos, dneg, opos, oneg;

    always_comb
    begin
        g64  = 64'(a_work_reg.g);
        m64  = 64'(a_work_reg.m);
        dpos = !a_work_reg.d[31] && (a_work_reg.d != '0);
        dneg = a_work_reg.d[31];
        opos = !a_work_reg.o[31] && (a_work_reg.o != '0);
        oneg = a_work_reg.o[31];
        base    = '0;
        addend  = a_q_reg;
        b_clamp = 1'b0;
        if (rule_mode_reg == qpu_pkg::RULE_MODIFIED)
        begin
            // Opposite-signed derivatives: secant step only.
            if (!((dpos && oneg) || (dneg && opos)))
                base = -g64;
            b_clamp = (dpos && opos) || (dneg && oneg);
        end
        else if (a_work_reg.s[31])
        begin
            if (dpos)
                base = -g64;
            if (a_work_reg.gt)
                addend = m64;
        end
        else if (a_work_reg.s != '0)
        begin
            if (dneg)
                base = -g64;
            if (a_work_reg.lt)
                addend = m64;
        end
        else
        begin
            base   = -g64;
            addend = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        b_work_reg  <= a_work_reg;
        b_delta_reg <= base + addend;
        b_clamp_reg <= b_clamp;
    end

    // Stage C: growth limit.
    logic [63:0] delta_abs;
    logic [63:0] lim64;

    always_comb
    begin
        delta_abs = b_delta_reg[63] ? 64'(-b_delta_reg) : 64'(b_delta_reg);
        lim64     = 64'(b_work_reg.lim);
    end

    always_ff @(posedge clk)
    begin
        c_work_reg <= b_work_reg;
        if (b_clamp_reg && delta_abs > lim64)
            c_delta_reg <= b_delta_reg[63] ? $signed(-lim64) : $signed(lim64);
        else
            c_delta_reg <= b_delta_reg;
    end

    // Stage D: saturate the step.
    always_ff @(posedge clk)
    begin
        d_work_reg <= c_work_reg;
        d_step_reg <= qpu_pkg::sat32(c_delta_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= dv_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Write back and result.
    logic signed [31:0] new_pt;
    logic               wb_we;
    qpu_pkg::ram_word_t wb_word;
    qpu_pkg::out_item_t result_next;

    always_comb
    begin
        new_pt = qpu_pkg::sat32(64'(d_work_reg.p) + 64'(d_step_reg));
        wb_we   = 1'b0;
        wb_word = '0;
        result_next.out_index = d_work_reg.idx;
        result_next.new_point = '0;
        result_next.new_step  = '0;
        result_next.skipped   = 1'b1;
        if (d_work_reg.in_range)
        begin
            if (d_work_reg.func == qpu_pkg::FUNC_LOAD)
            begin
                wb_we                 = d_valid_reg;
                wb_word.point         = d_work_reg.d;
                result_next.new_point = d_work_reg.d;
                result_next.skipped   = 1'b0;
            end
            else if (d_work_reg.eq)
            begin
                // Equal derivatives: leave the element as it is.
                result_next.new_point = d_work_reg.p;
            end
            else
            begin
                wb_we                 = d_valid_reg;
                wb_word.point         = new_pt;
                wb_word.deriv         = d_work_reg.d;
                wb_word.step          = d_step_reg;
                result_next.new_point = new_pt;
                result_next.new_step  = d_step_reg;
                result_next.skipped   = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = wb_we;
            ram_waddr = AW'(d_work_reg.idx);
            ram_wdata = wb_word;
        end
    end

    logic               done_reg;
    qpu_pkg::out_item_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
